@@ rtl/c_style_token_lexer_assert.svh @@
// Assertion macros for the C-style token lexer.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef C_STYLE_TOKEN_LEXER_ASSERT_SVH
`define C_STYLE_TOKEN_LEXER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define CTL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CTL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ctlex_pkg.sv @@
// Shared types, character codes and helper functions for the token lexer.
// No dependencies.
package ctlex_pkg;

    typedef enum logic [3:0] {
        M_IDLE   = 4'd0,
        M_WORD   = 4'd1,
        M_INT    = 4'd2,
        M_INTDOT = 4'd3,
        M_FRAC   = 4'd4,
        M_OPER   = 4'd5,
        M_SLASH  = 4'd6,
        M_LINE   = 4'd7,
        M_BLOCK  = 4'd8,
        M_BSTAR  = 4'd9,
        M_DOT    = 4'd10
    } t_mode;

    typedef enum logic [3:0] {
        TOK_KEY    = 4'd0,
        TOK_IDENT  = 4'd1,
        TOK_INT    = 4'd2,
        TOK_FLOAT  = 4'd3,
        TOK_OPER   = 4'd4,
        TOK_LBRACE = 4'd5,
        TOK_RBRACE = 4'd6,
        TOK_LPAREN = 4'd7,
        TOK_RPAREN = 4'd8,
        TOK_SEMI   = 4'd9
    } t_tok_type;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_source;
    } t_char_beat;

    typedef struct packed {
        t_tok_type   token_type;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic        last_of_item;
    } t_tok_beat;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam int NUM_KW = 6;
    localparam logic [47:0] KW_PACK [NUM_KW] = '{
        48'h0000_0069_6E74, 48'h0066_6C6F_6174, 48'h7374_7269_6E67,
        48'h0000_0000_6966, 48'h0077_6869_6C65, 48'h0070_7269_6E74
    };
    localparam logic [15:0] KW_LEN [NUM_KW] = '{
        16'd3, 16'd5, 16'd6, 16'd2, 16'd5, 16'd5
    };

    localparam logic [15:0] SIZE_SAT = 16'hFFFF;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
               c == CH_EQ || c == CH_GT || c == CH_LT;
    endfunction

    function automatic logic is_bracket(input logic [7:0] c);
        return c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACE || c == CH_RBRACE;
    endfunction

    // Saturating add of a small step to a token length.
    function automatic logic [15:0] grow(input logic [15:0] s, input logic [1:0] k);
        logic [16:0] sum;
        sum = {1'b0, s} + 17'(k);
        return sum[16] ? SIZE_SAT : sum[15:0];
    endfunction

    // Keyword when the length and the trailing window both match one entry.
    function automatic t_tok_type word_type(input logic [15:0] size,
                                            input logic [47:0] window);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_KW; i++) begin
            if (size == KW_LEN[i] && window == KW_PACK[i]) begin
                hit = 1'b1;
            end
        end
        return hit ? TOK_KEY : TOK_IDENT;
    endfunction

endpackage

@@ rtl/c_style_token_lexer.sv @@
// Top level of the C-style token lexer: mode state machine and token queue.
// Depends on ctlex_pkg, ctlex_fifo and c_style_token_lexer_assert.svh.
`include "c_style_token_lexer_assert.svh"

// Lexes a byte stream into token beats (type, start position, length).
// One source byte is taken per clock: the mode update and token decision for a
// byte are done in the same cycle it is accepted, and the zero, one or two
// token beats it produces are written straight into a FIFO_DEPTH-entry output
// queue. The output side delivers one beat per clock, so the byte port holds
// ready low only while fewer than two queue entries are free; with a
// downstream that takes beats every cycle the block runs at one byte per
// clock, and a byte that both ends a token and is a one-character token
// gives two beats. The last beat caused by a byte carries last_of_item.
// A byte flagged end_of_source flushes any pending token, drops an open
// comment or a lone dot, and restarts positions at zero. Positions count
// modulo 2^POSITION_BITS and token_start carries the low 16 bits; lengths
// saturate at 65535. No clearing pass follows reset.
module c_style_token_lexer #(
    parameter int POSITION_BITS = 16,
    parameter int FIFO_DEPTH    = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_char_valid,
    output logic                  o_char_ready,
    input  ctlex_pkg::t_char_beat i_char,
    output logic                  o_tok_valid,
    input  logic                  i_tok_ready,
    output ctlex_pkg::t_tok_beat  o_tok
);
    import ctlex_pkg::*;

    localparam int COUNT_W = $clog2(FIFO_DEPTH + 1);

    // Lexer state.
    t_mode                    r_mode,   n_mode;
    logic [15:0]              r_begin,  n_begin;
    logic [15:0]              r_size,   n_size;
    logic [POSITION_BITS-1:0] r_pos,    n_pos;
    logic [47:0]              r_window, n_window;

    logic        w_accept;
    logic [7:0]  w_c;
    logic        w_last;
    logic [31:0] w_pos_ext;
    logic [15:0] w_pos16;

    // Result of handling the byte in the current mode.
    logic        w_restart;
    t_mode       w_adv_mode;
    logic [15:0] w_adv_size;
    logic [47:0] w_adv_window;
    logic        w_adv_emit;
    t_tok_type   w_adv_type;
    logic [15:0] w_adv_len;

    // Result of handling the byte as a token start.
    t_mode       w_start_mode;
    logic        w_start_tok;
    logic        w_start_emit;
    t_tok_type   w_start_type;

    // State after the byte, before any end-of-source flush.
    t_mode       w_step_mode;
    logic [15:0] w_step_size;
    logic [15:0] w_step_begin;
    logic [47:0] w_step_window;

    logic        w_flush_emit;
    t_tok_type   w_flush_type;
    logic        w_se;

    t_tok_beat        w_adv_beat, w_start_beat, w_flush_beat;
    t_tok_beat        w_beat0, w_beat1;
    logic [1:0]       w_push_cnt;
    logic [COUNT_W-1:0] w_fifo_count;

    assign w_accept  = i_char_valid && o_char_ready;
    assign w_c       = i_char.character;
    assign w_last    = i_char.end_of_source;
    assign w_pos_ext = 32'(r_pos);
    assign w_pos16   = w_pos_ext[15:0];

    // Handle the byte in the current mode; flag it for a restart when it
    // ends the running token (or there is none).
    always_comb begin
        w_restart    = 1'b0;
        w_adv_mode   = r_mode;
        w_adv_size   = r_size;
        w_adv_window = r_window;
        w_adv_emit   = 1'b0;
        w_adv_type   = TOK_OPER;
        w_adv_len    = r_size;
        case (r_mode)
            M_WORD: begin
                if (is_alpha(w_c) || is_digit(w_c) || w_c == CH_UNDER) begin
                    w_adv_size   = grow(r_size, 2'd1);
                    w_adv_window = {r_window[39:0], w_c};
                end else begin
                    w_adv_emit = 1'b1;
                    w_adv_type = word_type(r_size, r_window);
                    w_restart  = 1'b1;
                end
            end
            M_INT: begin
                if (is_digit(w_c)) begin
                    w_adv_size = grow(r_size, 2'd1);
                end else if (w_c == CH_DOT) begin
                    w_adv_mode = M_INTDOT;
                end else begin
                    w_adv_emit = 1'b1;
                    w_adv_type = TOK_INT;
                    w_restart  = 1'b1;
                end
            end
            M_INTDOT: begin
                if (is_digit(w_c)) begin
                    w_adv_size = grow(r_size, 2'd2);
                    w_adv_mode = M_FRAC;
                end else begin
                    // drop the dot, emit the digits as an integer
                    w_adv_emit = 1'b1;
                    w_adv_type = TOK_INT;
                    w_restart  = 1'b1;
                end
            end
            M_FRAC: begin
                if (is_digit(w_c)) begin
                    w_adv_size = grow(r_size, 2'd1);
                end else begin
                    w_adv_emit = 1'b1;
                    w_adv_type = TOK_FLOAT;
                    w_restart  = 1'b1;
                end
            end
            M_DOT: begin
                if (is_digit(w_c)) begin
                    w_adv_size = 16'd2;
                    w_adv_mode = M_FRAC;
                end else begin
                    w_restart = 1'b1;
                end
            end
            M_SLASH, M_OPER: begin
                if (r_mode == M_SLASH && w_c == CH_SLASH) begin
                    w_adv_mode = M_LINE;
                end else if (r_mode == M_SLASH && w_c == CH_STAR) begin
                    w_adv_mode = M_BLOCK;
                end else begin
                    // a lone slash carries on as an operator run
                    w_adv_mode = M_OPER;
                    if (is_op(w_c)) begin
                        w_adv_size = grow(r_size, 2'd1);
                    end else if (is_bracket(w_c)) begin
                        // swallow one bracket into the run
                        w_adv_emit = 1'b1;
                        w_adv_len  = grow(r_size, 2'd1);
                        w_adv_mode = M_IDLE;
                    end else begin
                        w_adv_emit = 1'b1;
                        w_restart  = 1'b1;
                    end
                end
            end
            M_LINE: begin
                if (w_c == CH_NL) begin
                    w_adv_mode = M_IDLE;
                end
            end
            M_BLOCK: begin
                if (w_c == CH_STAR) begin
                    w_adv_mode = M_BSTAR;
                end
            end
            M_BSTAR: begin
                if (w_c == CH_SLASH) begin
                    w_adv_mode = M_IDLE;
                end else if (w_c != CH_STAR) begin
                    w_adv_mode = M_BLOCK;
                end
            end
            default: begin
                w_restart = 1'b1;
            end
        endcase
    end

    // Classify the byte as the first character of a token.
    always_comb begin
        w_start_mode = M_IDLE;
        w_start_tok  = 1'b0;
        w_start_emit = 1'b0;
        w_start_type = TOK_SEMI;
        if (is_alpha(w_c)) begin
            w_start_mode = M_WORD;
            w_start_tok  = 1'b1;
        end else if (is_digit(w_c)) begin
            w_start_mode = M_INT;
            w_start_tok  = 1'b1;
        end else if (w_c == CH_DOT) begin
            w_start_mode = M_DOT;
            w_start_tok  = 1'b1;
        end else if (w_c == CH_SLASH) begin
            w_start_mode = M_SLASH;
            w_start_tok  = 1'b1;
        end else if (is_op(w_c)) begin
            w_start_mode = M_OPER;
            w_start_tok  = 1'b1;
        end else if (w_c == CH_SEMI) begin
            w_start_emit = 1'b1;
            w_start_type = TOK_SEMI;
        end else if (w_c == CH_LPAREN) begin
            w_start_emit = 1'b1;
            w_start_type = TOK_LPAREN;
        end else if (w_c == CH_RPAREN) begin
            w_start_emit = 1'b1;
            w_start_type = TOK_RPAREN;
        end else if (w_c == CH_LBRACE) begin
            w_start_emit = 1'b1;
            w_start_type = TOK_LBRACE;
        end else if (w_c == CH_RBRACE) begin
            w_start_emit = 1'b1;
            w_start_type = TOK_RBRACE;
        end
    end

    assign w_se = w_restart && w_start_emit;

    // Next state: merge the mode step with a restart, then apply the flush.
    always_comb begin
        w_step_mode   = w_restart ? w_start_mode : w_adv_mode;
        w_step_size   = (w_restart && w_start_tok) ? 16'd1 : w_adv_size;
        w_step_begin  = (w_restart && w_start_tok) ? w_pos16 : r_begin;
        w_step_window = (w_restart && is_alpha(w_c)) ? {40'd0, w_c} : w_adv_window;

        n_mode   = w_last ? M_IDLE : w_step_mode;
        n_size   = w_last ? 16'd0 : w_step_size;
        n_begin  = w_step_begin;
        n_window = w_step_window;
        n_pos    = w_last ? '0 : r_pos + POSITION_BITS'(1);
    end

    // Outputs: up to two token beats, in the order the model gives them.
    always_comb begin
        w_flush_emit = 1'b0;
        w_flush_type = TOK_OPER;
        case (w_step_mode)
            M_WORD: begin
                w_flush_emit = w_last;
                w_flush_type = word_type(w_step_size, w_step_window);
            end
            M_INT, M_INTDOT: begin
                w_flush_emit = w_last;
                w_flush_type = TOK_INT;
            end
            M_FRAC: begin
                w_flush_emit = w_last;
                w_flush_type = TOK_FLOAT;
            end
            M_OPER, M_SLASH: begin
                w_flush_emit = w_last;
                w_flush_type = TOK_OPER;
            end
            default: begin
                w_flush_emit = 1'b0;
            end
        endcase

        w_adv_beat   = '{token_type: w_adv_type, token_start: r_begin,
                         token_length: w_adv_len, last_of_item: 1'b0};
        w_start_beat = '{token_type: w_start_type, token_start: w_pos16,
                         token_length: 16'd1, last_of_item: 1'b0};
        w_flush_beat = '{token_type: w_flush_type, token_start: w_step_begin,
                         token_length: w_step_size, last_of_item: 1'b0};

        w_push_cnt = 2'(w_adv_emit) + 2'(w_se) + 2'(w_flush_emit);
        if (w_adv_emit) begin
            w_beat0 = w_adv_beat;
        end else if (w_se) begin
            w_beat0 = w_start_beat;
        end else begin
            w_beat0 = w_flush_beat;
        end
        if (w_adv_emit && w_se) begin
            w_beat1 = w_start_beat;
        end else begin
            w_beat1 = w_flush_beat;
        end
        w_beat0.last_of_item = (w_push_cnt == 2'd1);
        w_beat1.last_of_item = 1'b1;
        if (!w_accept) begin
            w_push_cnt = 2'd0;
        end
    end

    // Advance the lexer state only on an accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_begin  <= '0;
            r_size   <= '0;
            r_pos    <= '0;
            r_window <= '0;
        end else if (w_accept) begin
            r_mode   <= n_mode;
            r_begin  <= n_begin;
            r_size   <= n_size;
            r_pos    <= n_pos;
            r_window <= n_window;
        end
    end

    // Hold the byte port while the queue cannot take a worst-case pair.
    assign o_char_ready = w_fifo_count <= COUNT_W'(FIFO_DEPTH - 2);

    ctlex_fifo #(
        .WIDTH ($bits(t_tok_beat)),
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push_cnt),
        .i_data0    (w_beat0),
        .i_data1    (w_beat1),
        .o_valid    (o_tok_valid),
        .i_ready    (i_tok_ready),
        .o_data     (o_tok),
        .o_count    (w_fifo_count)
    );

    `CTL_ASSERT_IMPL(a_queue_bound, 1'b1, w_fifo_count <= COUNT_W'(FIFO_DEPTH), "token queue overflow")
    `CTL_ASSERT_IMPL(a_len_nonzero, o_tok_valid, o_tok.token_length != 16'd0, "zero-length token beat")
    `CTL_ASSERT_NEXT(a_end_restart, w_accept && w_last, r_mode == M_IDLE && r_pos == '0, "end of source did not restart lexer")

endmodule

@@ rtl/ctlex_fifo.sv @@
// Small token queue: takes up to two beats per cycle, gives one per ready cycle.
// Depends on nothing but its parameters; DEPTH must be a power of two.
module ctlex_fifo #(
    parameter int WIDTH = 37,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [1:0]                 i_push_cnt,
    input  logic [WIDTH-1:0]           i_data0,
    input  logic [WIDTH-1:0]           i_data1,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_pop;
    logic [PTR_W-1:0] w_wr_ptr1;

    assign o_valid   = r_count != '0;
    assign o_data    = r_mem[r_rd_ptr];
    assign o_count   = r_count;
    assign w_pop     = o_valid && i_ready;
    assign w_wr_ptr1 = r_wr_ptr + PTR_W'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(i_push_cnt);
        n_rd_ptr = r_rd_ptr + PTR_W'(w_pop);
        n_count  = r_count + CNT_W'(i_push_cnt) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[w_wr_ptr1] <= i_data1;
        end
    end

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for c_style_token_lexer: byte stream in, token beats out.
// Depends on ctlex_pkg and the lexer RTL; a built-in token predictor supplies expectations.
`timescale 1ns / 1ps

module testbench;
    import ctlex_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_PRINTED = 40;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR = 8'h0D;

    // Keyword spellings, right aligned in the six-byte word window.
    localparam logic [47:0] KW_INT = "int";
    localparam logic [47:0] KW_FLOAT = "float";
    localparam logic [47:0] KW_STRING = "string";
    localparam logic [47:0] KW_IF = "if";
    localparam logic [47:0] KW_WHILE = "while";
    localparam logic [47:0] KW_PRINT = "print";

    // Drive every input to a known value from time zero.
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_char_valid = 1'b0;
    t_char_beat i_char = '0;
    logic       i_tok_ready = 1'b0;
    logic       o_char_ready;
    logic       o_tok_valid;
    t_tok_beat  o_tok;

    c_style_token_lexer uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_valid (i_char_valid),
        .o_char_ready (o_char_ready),
        .i_char       (i_char),
        .o_tok_valid  (o_tok_valid),
        .i_tok_ready  (i_tok_ready),
        .o_tok        (o_tok)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Pacing knobs, in percent of cycles spent idle.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int cycle_count = 0;
    int error_count = 0;
    int bytes_sent = 0;
    int beats_checked = 0;

    // Predicted token beats, oldest first.
    t_tok_beat token_expect_q[$];

    // Predictor state: a private copy of the lexer's mode and token registers.
    t_mode       lex_mode = M_IDLE;
    logic [15:0] lex_begin = '0;
    logic [15:0] lex_size = '0;
    logic [15:0] lex_pos = '0;
    logic [47:0] lex_window = '0;

    // Bytes of one random source fragment, built before it is sent.
    logic [7:0] piece_q[$];

    // ------------------------------------------------------------------
    // Character classes and token arithmetic of the predictor.
    // ------------------------------------------------------------------
    function automatic logic char_is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic char_is_numeral(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic char_is_operator(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
               c == CH_EQ || c == CH_GT || c == CH_LT;
    endfunction

    function automatic logic char_is_paren_or_brace(input logic [7:0] c);
        return c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACE || c == CH_RBRACE;
    endfunction

    // Saturate token lengths at the top of the 16-bit range.
    function automatic logic [15:0] length_plus(input logic [15:0] s, input int k);
        logic [16:0] sum;
        sum = {1'b0, s} + 17'(k);
        return sum[16] ? 16'hFFFF : sum[15:0];
    endfunction

    // Classify the pending word: keyword only if length and window both match.
    function automatic t_tok_type word_token_kind();
        if ((lex_size == 16'd3 && lex_window == KW_INT) ||
            (lex_size == 16'd5 && lex_window == KW_FLOAT) ||
            (lex_size == 16'd6 && lex_window == KW_STRING) ||
            (lex_size == 16'd2 && lex_window == KW_IF) ||
            (lex_size == 16'd5 && lex_window == KW_WHILE) ||
            (lex_size == 16'd5 && lex_window == KW_PRINT)) begin
            return TOK_KEY;
        end
        return TOK_IDENT;
    endfunction

    task automatic expect_token(input t_tok_type kind, input logic [15:0] start,
                                input logic [15:0] len);
        t_tok_beat t;
        t.token_type = kind;
        t.token_start = start;
        t.token_length = len;
        t.last_of_item = 1'b0;
        token_expect_q.insert(token_expect_q.size(), t);
    endtask

    // Handle a byte seen between tokens: open a token or emit a one-char one.
    task automatic open_token(input logic [7:0] c, input logic [15:0] pos);
        lex_mode = M_IDLE;
        if (char_is_letter(c)) begin
            lex_mode = M_WORD;
            lex_begin = pos;
            lex_size = 16'd1;
            lex_window = {40'd0, c};
        end else if (char_is_numeral(c)) begin
            lex_mode = M_INT;
            lex_begin = pos;
            lex_size = 16'd1;
        end else if (c == CH_DOT) begin
            lex_mode = M_DOT;
            lex_begin = pos;
            lex_size = 16'd1;
        end else if (c == CH_SLASH) begin
            lex_mode = M_SLASH;
            lex_begin = pos;
            lex_size = 16'd1;
        end else if (char_is_operator(c)) begin
            lex_mode = M_OPER;
            lex_begin = pos;
            lex_size = 16'd1;
        end else if (c == CH_SEMI) begin
            expect_token(TOK_SEMI, pos, 16'd1);
        end else if (c == CH_LPAREN) begin
            expect_token(TOK_LPAREN, pos, 16'd1);
        end else if (c == CH_RPAREN) begin
            expect_token(TOK_RPAREN, pos, 16'd1);
        end else if (c == CH_LBRACE) begin
            expect_token(TOK_LBRACE, pos, 16'd1);
        end else if (c == CH_RBRACE) begin
            expect_token(TOK_RBRACE, pos, 16'd1);
        end
    endtask

    // Advance the predictor by one accepted byte and queue the beats it causes.
    task automatic predict_tokens(input t_char_beat b);
        logic [7:0]  c;
        logic [15:0] pos;
        logic        restart;
        int          queued;
        c = b.character;
        pos = lex_pos;
        restart = 1'b0;
        queued = token_expect_q.size();
        case (lex_mode)
            M_WORD: begin
                if (char_is_letter(c) || char_is_numeral(c) || c == CH_UNDER) begin
                    lex_size = length_plus(lex_size, 1);
                    lex_window = {lex_window[39:0], c};
                end else begin
                    expect_token(word_token_kind(), lex_begin, lex_size);
                    restart = 1'b1;
                end
            end
            M_INT: begin
                if (char_is_numeral(c)) begin
                    lex_size = length_plus(lex_size, 1);
                end else if (c == CH_DOT) begin
                    lex_mode = M_INTDOT;
                end else begin
                    expect_token(TOK_INT, lex_begin, lex_size);
                    restart = 1'b1;
                end
            end
            M_INTDOT: begin
                // The dot joins the length only once a fraction digit follows.
                if (char_is_numeral(c)) begin
                    lex_size = length_plus(lex_size, 2);
                    lex_mode = M_FRAC;
                end else begin
                    expect_token(TOK_INT, lex_begin, lex_size);
                    restart = 1'b1;
                end
            end
            M_FRAC: begin
                if (char_is_numeral(c)) begin
                    lex_size = length_plus(lex_size, 1);
                end else begin
                    expect_token(TOK_FLOAT, lex_begin, lex_size);
                    restart = 1'b1;
                end
            end
            M_DOT: begin
                // Drop a lone dot; a digit turns it into a float.
                if (char_is_numeral(c)) begin
                    lex_size = 16'd2;
                    lex_mode = M_FRAC;
                end else begin
                    restart = 1'b1;
                end
            end
            M_SLASH, M_OPER: begin
                if (lex_mode == M_SLASH && c == CH_SLASH) begin
                    lex_mode = M_LINE;
                end else if (lex_mode == M_SLASH && c == CH_STAR) begin
                    lex_mode = M_BLOCK;
                end else begin
                    // A slash without a comment partner is a plain operator run.
                    lex_mode = M_OPER;
                    if (char_is_operator(c)) begin
                        lex_size = length_plus(lex_size, 1);
                    end else if (char_is_paren_or_brace(c)) begin
                        expect_token(TOK_OPER, lex_begin, length_plus(lex_size, 1));
                        lex_mode = M_IDLE;
                    end else begin
                        expect_token(TOK_OPER, lex_begin, lex_size);
                        restart = 1'b1;
                    end
                end
            end
            M_LINE: begin
                if (c == CH_NL) begin
                    lex_mode = M_IDLE;
                end
            end
            M_BLOCK: begin
                if (c == CH_STAR) begin
                    lex_mode = M_BSTAR;
                end
            end
            M_BSTAR: begin
                if (c == CH_SLASH) begin
                    lex_mode = M_IDLE;
                end else if (c != CH_STAR) begin
                    lex_mode = M_BLOCK;
                end
            end
            default: begin
                restart = 1'b1;
            end
        endcase
        if (restart) begin
            open_token(c, pos);
        end
        if (b.end_of_source) begin
            // Flush the pending token; open comments and a lone dot vanish.
            case (lex_mode)
                M_WORD: expect_token(word_token_kind(), lex_begin, lex_size);
                M_INT, M_INTDOT: expect_token(TOK_INT, lex_begin, lex_size);
                M_FRAC: expect_token(TOK_FLOAT, lex_begin, lex_size);
                M_OPER, M_SLASH: expect_token(TOK_OPER, lex_begin, lex_size);
                default: ;
            endcase
            lex_mode = M_IDLE;
            lex_size = '0;
            lex_pos = '0;
        end else begin
            lex_pos = pos + 16'd1;
        end
        if (token_expect_q.size() > queued) begin
            token_expect_q[token_expect_q.size() - 1].last_of_item = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Mismatch reporting.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTED) begin
            $display("MISMATCH @%0d: %s", cycle_count, what);
        end
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Receiver pacing, prediction and checking, all sampled at the edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_tok_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_tok_beat want;
        cycle_count++;
        if (i_rst_n) begin
            // Predict first so a beat of this same edge always finds its entry.
            if (i_char_valid && o_char_ready) begin
                predict_tokens(i_char);
            end
            if (o_tok_valid && i_tok_ready) begin
                beats_checked++;
                if (token_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat type %0d start %0d len %0d",
                                              o_tok.token_type, o_tok.token_start,
                                              o_tok.token_length));
                end else begin
                    want = token_expect_q.pop_front();
                    if (o_tok.token_type !== want.token_type) begin
                        report_mismatch($sformatf("token_type got %0d want %0d",
                                                  o_tok.token_type, want.token_type));
                    end
                    if (o_tok.token_start !== want.token_start) begin
                        report_mismatch($sformatf("token_start got %0d want %0d",
                                                  o_tok.token_start, want.token_start));
                    end
                    if (o_tok.token_length !== want.token_length) begin
                        report_mismatch($sformatf("token_length got %0d want %0d",
                                                  o_tok.token_length, want.token_length));
                    end
                    if (o_tok.last_of_item !== want.last_of_item) begin
                        report_mismatch($sformatf("last_of_item got %0b want %0b",
                                                  o_tok.last_of_item, want.last_of_item));
                    end
                end
            end
        end
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------

    // Send one byte beat. Drop valid only when an idle gap is taken, so that
    // back-to-back beats keep valid high with a single assignment per edge.
    task automatic send_char(input logic [7:0] c, input logic eos);
        t_char_beat b;
        b.character = c;
        b.end_of_source = eos;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_char_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_char_valid <= 1'b1;
        i_char <= b;
        do @(posedge i_clk); while (!o_char_ready);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input logic eos_last);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], eos_last && (i == s.len() - 1));
        end
    endtask

    // Append one byte to the fragment under construction.
    task automatic add_byte(input logic [7:0] c);
        piece_q.insert(piece_q.size(), c);
    endtask

    function automatic logic [7:0] pick_letter();
        if ($urandom_range(0, 1) == 0) begin
            return 8'("a") + 8'($urandom_range(0, 25));
        end
        return 8'("A") + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] pick_numeral();
        return 8'("0") + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 6))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_STAR;
            3: return CH_SLASH;
            4: return CH_EQ;
            5: return CH_GT;
            default: return CH_LT;
        endcase
    endfunction

    function automatic logic [7:0] pick_single();
        case ($urandom_range(0, 4))
            0: return CH_LPAREN;
            1: return CH_RPAREN;
            2: return CH_LBRACE;
            3: return CH_RBRACE;
            default: return CH_SEMI;
        endcase
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 3))
            0: return CH_TAB;
            1: return CH_NL;
            2: return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic string pick_keyword();
        case ($urandom_range(0, 5))
            0: return "int";
            1: return "float";
            2: return "string";
            3: return "if";
            4: return "while";
            default: return "print";
        endcase
    endfunction

    // Append a word body byte: letter, digit or underscore.
    task automatic push_word_char();
        case ($urandom_range(0, 5))
            0, 1, 2: add_byte(pick_letter());
            3, 4: add_byte(pick_numeral());
            default: add_byte(CH_UNDER);
        endcase
    endtask

    // Build one source fragment: mostly well-formed lexemes, some noise.
    task automatic build_piece();
        string kw;
        int    n;
        piece_q.delete();
        case ($urandom_range(0, 19))
            0, 1, 2: begin
                // Keyword, sometimes cut short or extended into an identifier.
                kw = pick_keyword();
                n = kw.len();
                if ($urandom_range(0, 3) == 0 && n > 1) begin
                    n = n - 1;
                end
                for (int i = 0; i < n; i++) begin
                    add_byte(kw[i]);
                end
                if ($urandom_range(0, 4) == 0) begin
                    push_word_char();
                end
            end
            3, 4: begin
                add_byte(pick_letter());
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 14) : $urandom_range(0, 4);
                for (int i = 0; i < n; i++) begin
                    push_word_char();
                end
            end
            5, 6: begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    add_byte(pick_numeral());
                end
                // Sometimes a dot follows, with or without a fraction.
                if ($urandom_range(0, 2) == 0) begin
                    add_byte(CH_DOT);
                    n = $urandom_range(0, 3);
                    for (int i = 0; i < n; i++) begin
                        add_byte(pick_numeral());
                    end
                end
            end
            7: begin
                add_byte(CH_DOT);
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) begin
                    add_byte(pick_numeral());
                end
            end
            8, 9: begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) begin
                    add_byte(pick_operator());
                end
                if ($urandom_range(0, 2) == 0) begin
                    add_byte(pick_single());
                end
            end
            10, 11, 12: begin
                add_byte(pick_single());
            end
            13: begin
                add_byte(CH_SLASH);
                add_byte(CH_SLASH);
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) begin
                    add_byte(8'($urandom_range(8'h20, 8'h7E)));
                end
                add_byte(CH_NL);
            end
            14: begin
                // Block comment with stray stars and slashes inside.
                add_byte(CH_SLASH);
                add_byte(CH_STAR);
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(0, 3))
                        0: add_byte(CH_STAR);
                        1: add_byte(CH_SLASH);
                        default: add_byte(pick_letter());
                    endcase
                end
                if ($urandom_range(0, 1) == 0) begin
                    add_byte(CH_STAR);
                end
                add_byte(CH_STAR);
                add_byte(CH_SLASH);
            end
            15, 16, 17: begin
                n = $urandom_range(1, 2);
                for (int i = 0; i < n; i++) begin
                    add_byte(pick_space());
                end
            end
            default: begin
                add_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Wait until every predicted beat has arrived, then let the clock run on.
    task automatic wait_for_drain();
        while (token_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Keyword, identifier with digit and underscore, operator run that takes a
    // brace, float, block comment, dot-led float, integer before a lone dot,
    // semicolon and a lone slash flushed at end of source.
    task automatic test_token_kinds();
        send_text("if(x_1=>{2.5/*a*/.7 3.;/", 1'b1);
    endtask

    // Line comment, dropped lone dot, unrecognized high and NUL bytes, and a
    // block comment left open by end of source.
    task automatic test_comments_and_noise();
        send_text("}//\n.", 1'b0);
        send_char(8'h80, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_text(")/*", 1'b1);
    endtask

    task automatic test_random_source(input int n_bytes);
        int sent;
        sent = 0;
        while (sent < n_bytes) begin
            build_piece();
            foreach (piece_q[i]) begin
                send_char(piece_q[i], $urandom_range(0, 59) == 0);
                sent++;
            end
        end
        // Close the source so the next test starts at position zero.
        send_char(CH_SPACE, 1'b1);
    endtask

    initial begin
        send_idle_pct = 14;
        recv_idle_pct = 74;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_token_kinds();
        test_comments_and_noise();
        test_random_source(440);

        send_idle_pct = 74;
        recv_idle_pct = 14;
        test_random_source(440);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_source(440);

        i_char_valid <= 1'b0;
        wait_for_drain();
        if (token_expect_q.size() != 0) begin
            report_mismatch($sformatf("%0d token beats never arrived", token_expect_q.size()));
        end

        $display("Run covered %0d source bytes and %0d token beats under three pacing mixes,",
                 bytes_sent, beats_checked);
        $display("including keywords, comments, noise bytes and end-of-source flushes.");
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
